FILE: sv/toq_pkg.sv
`timescale 1ns / 1ps
package toq_pkg;
   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_DROP = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_EXEC  = 2'd1,
      FSM_REPLY = 2'd2
   } fsm_type;

   typedef struct packed {
      logic    load;
      logic    exec;
      logic    reply;
   } ctl_type;

   typedef struct packed {
      logic    done;
   } sts_type;

   localparam int LIMIT_BITS = 6;
   localparam int COUNT_BITS = 7;
endpackage

FILE: sv/toq_ctrl.sv
`timescale 1ns / 1ps
module toq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output toq_pkg::ctl_type ctl,
   input  toq_pkg::sts_type sts
);
   import toq_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:  if (start) state_in = FSM_EXEC;
         FSM_EXEC:  if (sts.done) state_in = FSM_REPLY;
         FSM_REPLY: state_in = FSM_IDLE;
         default:   state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      busy = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            ctl.load = start;
         end
         FSM_EXEC:  ctl.exec = 1'b1;
         FSM_REPLY: ctl.reply = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.exec, ctl.reply}))
      else $error("control overlap");
   a_reply_after: assert property (@(posedge clock) disable iff (reset)
      ctl.reply |-> $past(ctl.exec))
      else $error("reply without exec");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> ctl.exec)
      else $error("load not followed by exec");
endmodule

FILE: sv/toq_dpath.sv
`timescale 1ns / 1ps
module toq_dpath #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  toq_pkg::ctl_type               ctl,
   output toq_pkg::sts_type               sts,
   input  logic                           csr_we,
   input  logic [toq_pkg::LIMIT_BITS-1:0] csr_wdata,
   input  logic [1:0]                     req_command,
   input  logic [TAG_BITS-1:0]            req_packet_tag,
   input  logic [TIME_BITS-1:0]           req_entry_time,
   input  logic [TIME_BITS-1:0]           req_current_time,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [TAG_BITS-1:0]            rsp_out_tag,
   output logic [TIME_BITS-1:0]           rsp_out_time,
   output logic [toq_pkg::COUNT_BITS-1:0] rsp_entry_count
);
   import toq_pkg::*;

   localparam int CB = $clog2(QUEUE_DEPTH + 1);
   localparam int IB = $clog2(QUEUE_DEPTH);

   logic [TIME_BITS-1:0]  time_ff [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]   tag_ff  [QUEUE_DEPTH];
   logic [CB-1:0]         count_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [1:0]            cmd_ff;
   logic [TAG_BITS-1:0]   ptag_ff;
   logic [TIME_BITS-1:0]  etime_ff, now_ff;
   logic [1:0]            status_ff;
   logic [TAG_BITS-1:0]   otag_ff;
   logic [TIME_BITS-1:0]  otime_ff;

   logic [QUEUE_DEPTH-1:0] valid, after, shl, ins_here;
   logic                   full, do_enq, do_rem, drop_ok;
   logic [CB-1:0]          rpos;
   logic [CB:0]            lim_ext;
   logic [TAG_BITS-1:0]    sel_tag;
   logic [TIME_BITS-1:0]   sel_time;

   assign full    = (count_ff == CB'(QUEUE_DEPTH));
   assign lim_ext = (CB + 1)'(limit_ff);
   assign sel_tag  = (cmd_ff == CMD_DEQ) ? tag_ff[0] : tag_ff[IB'(limit_ff)];
   assign sel_time = (cmd_ff == CMD_DEQ) ? time_ff[0] : time_ff[IB'(limit_ff)];
   assign drop_ok = (cmd_ff == CMD_DROP) && ((CB + 1)'(count_ff) > lim_ext)
                    && (lim_ext < (CB + 1)'(QUEUE_DEPTH)) && (sel_time <= now_ff);
   assign do_enq  = (cmd_ff == CMD_ENQ) && !full;
   assign do_rem  = ((cmd_ff == CMD_DEQ) && (count_ff != '0)) || drop_ok;
   assign rpos    = (cmd_ff == CMD_DEQ) ? '0 : CB'(limit_ff);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid[i] = (CB + 1)'(i) < (CB + 1)'(count_ff);
         after[i] = valid[i] && (time_ff[i] > etime_ff);
         shl[i]   = valid[i] && ((CB + 1)'(i) >= (CB + 1)'(rpos));
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ins_here[i] = (valid[i] ? after[i] : 1'b1)
                       && ((i == 0) ? 1'b1 : (valid[i-1] && !after[i-1]));
      end
   end

   assign sts.done = ctl.exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_BITS'(32);
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctl.exec;
         if (csr_we) limit_ff <= csr_wdata;
         if (ctl.exec) begin
            if (do_enq) count_ff <= count_ff + 1'b1;
            else if (do_rem) count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         ptag_ff  <= req_packet_tag;
         etime_ff <= req_entry_time;
         now_ff   <= req_current_time;
      end
      if (ctl.exec) begin
         if (cmd_ff == CMD_ENQ) begin
            status_ff <= full ? ST_FULL : ST_DONE;
            otag_ff   <= '0;
            otime_ff  <= '0;
         end else if (do_rem) begin
            status_ff <= ST_DONE;
            otag_ff   <= sel_tag;
            otime_ff  <= sel_time;
         end else begin
            status_ff <= ST_NONE;
            otag_ff   <= '0;
            otime_ff  <= '0;
         end
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (do_enq) begin
               if (ins_here[i]) begin
                  time_ff[i] <= etime_ff;
                  tag_ff[i]  <= ptag_ff;
               end else if (i > 0 && after[i-1]) begin
                  time_ff[i] <= time_ff[i-1];
                  tag_ff[i]  <= tag_ff[i-1];
               end
            end else if (do_rem && shl[i] && i + 1 < QUEUE_DEPTH) begin
               time_ff[i] <= time_ff[(i + 1) % QUEUE_DEPTH];
               tag_ff[i]  <= tag_ff[(i + 1) % QUEUE_DEPTH];
            end
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_out_tag     = otag_ff;
   assign rsp_out_time    = otime_ff;
   assign rsp_entry_count = COUNT_BITS'(count_ff);

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(QUEUE_DEPTH))
      else $error("count overflow");
   a_full_keep: assert property (@(posedge clock) disable iff (reset)
      (ctl.exec && cmd_ff == CMD_ENQ && full) |=> (count_ff == $past(count_ff)))
      else $error("full enqueue changed count");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_out_tag == '0 && rsp_out_time == '0))
      else $error("nonzero payload on failure");
endmodule

FILE: sv/timestamp_ordered_queue_with_overflow_unit.sv
`timescale 1ns / 1ps
// response: operands load with start, the shift array updates in EXEC, and rsp_valid is high in REPLY
// a new request is taken only in IDLE, after REPLY; busy is high until then, set by the controller sequence
// the sorted cell array inserts or removes with a single parallel shift
// reset: synchronous, clears count to 0 and buffer limit to 32
// rsp_valid pulses for one cycle; the receiver cannot stall
module timestamp_ordered_queue_with_overflow_unit #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           csr_we,
   input  logic [toq_pkg::LIMIT_BITS-1:0] csr_wdata,
   input  logic [1:0]                     req_command,
   input  logic [TAG_BITS-1:0]            req_packet_tag,
   input  logic [TIME_BITS-1:0]           req_entry_time,
   input  logic [TIME_BITS-1:0]           req_current_time,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [TAG_BITS-1:0]            rsp_out_tag,
   output logic [TIME_BITS-1:0]           rsp_out_time,
   output logic [toq_pkg::COUNT_BITS-1:0] rsp_entry_count
);
   import toq_pkg::*;

   ctl_type ctl;
   sts_type sts;

   toq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .ctl(ctl), .sts(sts)
   );

   toq_dpath #(
      .QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS), .TAG_BITS(TAG_BITS)
   ) u_dpath (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_command(req_command), .req_packet_tag(req_packet_tag),
      .req_entry_time(req_entry_time), .req_current_time(req_current_time),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_out_tag(rsp_out_tag),
      .rsp_out_time(rsp_out_time), .rsp_entry_count(rsp_entry_count)
   );
endmodule
